// ===== sv/rgg_pkg.sv =====
// rgg_pkg: shared types and constants for the reduced gaussian grid indexer
// no dependencies
package rgg_pkg;

   localparam int MaxRows      = 2048;
   localparam int RowBits      = 11;
   localparam int ColBits      = 13;
   localparam int EndBits      = 25;
   localparam int IdxBits      = 24;
   localparam int LonBits      = 29;
   localparam int LatBits      = 28;
   localparam int MaxRowPoints = 8191;
   // dividend width: col*360 << 20 (col < 8192)
   localparam int DvdBits      = 42;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_INDEX = 2'd1,
      OP_COLROW = 2'd2,
      OP_BAD   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]               operation;
      logic [RowBits-1:0]       row;
      logic [ColBits-1:0]       column;
      logic [ColBits-1:0]       points;
      logic signed [LatBits-1:0] latitude;
      logic [IdxBits-1:0]       flat_index;
   } req_type;

   typedef struct packed {
      logic                      status;
      logic [RowBits-1:0]        row_found;
      logic [ColBits-1:0]        column_found;
      logic [IdxBits-1:0]        index_found;
      logic [LonBits-1:0]        longitude;
      logic signed [LatBits-1:0] latitude_out;
   } rsp_type;

   // one row entry as held in the row table
   typedef struct packed {
      logic [ColBits-1:0] points;
      logic [EndBits-1:0] end_off;
      logic [LatBits-1:0] lat;
   } entry_type;

endpackage

// ===== sv/rgg_row_mem.sv =====
// rgg_row_mem: row table (points, end offset, latitude), one read and one write port
// depends on rgg_pkg
module rgg_row_mem (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [rgg_pkg::RowBits-1:0]      wr_addr,
   input  rgg_pkg::entry_type               wr_data,
   input  logic [rgg_pkg::RowBits-1:0]      rd_addr,
   output rgg_pkg::entry_type               rd_data
);

   rgg_pkg::entry_type mem [rgg_pkg::MaxRows];
   rgg_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rgg_divider.sv =====
// rgg_divider: restoring divider, one quotient bit per cycle
// depends on rgg_pkg
module rgg_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rgg_pkg::DvdBits-1:0]      dividend,
   input  logic [rgg_pkg::ColBits-1:0]      divisor,
   output logic                             done,
   output logic [rgg_pkg::LonBits-1:0]      quotient
);

   localparam int CntBits = $clog2(rgg_pkg::DvdBits + 1);

   logic [rgg_pkg::DvdBits-1:0] quo_ff, quo_in;
   logic [rgg_pkg::ColBits:0]   rem_ff, rem_in;
   logic [rgg_pkg::ColBits-1:0] dsr_ff, dsr_in;
   logic [CntBits-1:0]          cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [rgg_pkg::ColBits+1:0] trial;
   logic [rgg_pkg::ColBits+1:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[rgg_pkg::DvdBits-1]};
      trial   = shifted - {2'b00, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntBits'(rgg_pkg::DvdBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below divisor, so shifted fits ColBits+1 bits
         if (!trial[rgg_pkg::ColBits+1]) begin
            rem_in = trial[rgg_pkg::ColBits:0];
            quo_in = {quo_ff[rgg_pkg::DvdBits-2:0], 1'b1};
         end else begin
            rem_in = shifted[rgg_pkg::ColBits:0];
            quo_in = {quo_ff[rgg_pkg::DvdBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[rgg_pkg::LonBits-1:0];

endmodule

// ===== sv/reduced_gaussian_grid_indexer_top.sv =====
// reduced_gaussian_grid_indexer_top: row table with load, index and column/row queries
// depends on rgg_pkg, rgg_row_mem, rgg_divider
//
//   channel   dir   ports                      word
//   req       in    req_valid/ready/data       rgg_pkg::req_type
//   rsp       out   rsp_valid/ready/data       rgg_pkg::rsp_type
//   csr       in    csr_valid/ready/data       half_rows, 11 bit
//
// one word at a time; a load reads the previous row end (none for row 0), then writes
// the row; a column/row query reads the previous row end and the row, then runs the
// serial longitude divider; an index query binary-searches the row ends first
// a finished word sits in the rsp register; the next req is taken once it is read
// no clearing pass after reset; half_rows resets to 1
module reduced_gaussian_grid_indexer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rgg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rgg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgg_pkg::RowBits-1:0]         csr_data
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RD     = 8'b0000_0010, // read issued, data next cycle
      S_PREV   = 8'b0000_0100, // load: previous row end in hand
      S_SRCH   = 8'b0000_1000, // index: search step compare
      S_FIN    = 8'b0001_0000, // fetch row and previous row
      S_FIN2   = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   localparam int RB = rgg_pkg::RowBits;

   state_type          st_ff, st_in;
   rgg_pkg::req_type   req_ff, req_in;
   rgg_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;
   logic [RB-1:0]      half_ff;
   logic [RB:0]        rows;
   logic [RB-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [1:0]         phase_ff, phase_in;
   logic [rgg_pkg::EndBits-1:0] start_ff, start_in;
   rgg_pkg::entry_type ent_ff, ent_in;
   logic [RB-1:0]      rd_addr;
   rgg_pkg::entry_type rd_data, wr_data;
   logic               wr_en;
   logic               div_start, div_done;
   logic [rgg_pkg::LonBits-1:0] quo;
   logic [rgg_pkg::DvdBits-1:0] dvd;
   logic [rgg_pkg::ColBits-1:0] pts_sat;
   logic [rgg_pkg::ColBits+8:0] col360;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= RB'(1);
      end else if (csr_valid) begin
         half_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   // 2*half_rows capped at the table depth
   always_comb begin
      rows = {half_ff, 1'b0};
      if (rows > (RB+1)'(rgg_pkg::MaxRows)) rows = (RB+1)'(rgg_pkg::MaxRows);
   end

   assign mid = RB'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign pts_sat = req_ff.points; // 13 bit field cannot exceed the cap
   assign col360 = (rgg_pkg::ColBits+9)'(rsp_ff.column_found) * 22'd360;
   assign dvd = {col360, 20'd0};

   rgg_row_mem u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_ff.row),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rgg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dvd),
      .divisor (ent_ff.points),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      st_in     = st_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      rspv_in   = rspv_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      phase_in  = phase_ff;
      start_in  = start_ff;
      ent_in    = ent_ff;
      rd_addr   = req_ff.row;
      wr_en     = 1'b0;
      wr_data.points  = pts_sat;
      wr_data.lat     = req_ff.latitude;
      wr_data.end_off = start_ff + rgg_pkg::EndBits'(pts_sat);
      div_start = 1'b0;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && !rspv_ff) begin
               req_in = req_data;
               rsp_in = '0;
               start_in = '0;
               phase_in = 2'd0;
               st_in = S_RD;
               unique case (rgg_pkg::op_type'(req_data.operation))
                  rgg_pkg::OP_LOAD: begin
                     if ({1'b0, req_data.row} >= rows) begin
                        rsp_in.status = 1'b1;
                        st_in = S_OUT;
                     end else if (req_data.row == '0) begin
                        st_in = S_PREV;
                     end
                     rd_addr = req_data.row - 1'b1;
                  end
                  rgg_pkg::OP_INDEX: begin
                     if (rows == '0) begin
                        rsp_in.status = 1'b1;
                        st_in = S_OUT;
                     end
                     rd_addr = RB'(rows - 1'b1);
                     lo_in = '0;
                     hi_in = RB'(rows - 1'b1);
                  end
                  rgg_pkg::OP_COLROW: begin
                     if ({1'b0, req_data.row} >= rows) begin
                        rsp_in.status = 1'b1;
                        st_in = S_OUT;
                     end
                     rd_addr = req_data.row - 1'b1;
                  end
                  rgg_pkg::OP_BAD: begin
                     rsp_in.status = 1'b1;
                     st_in = S_OUT;
                  end
                  default: st_in = S_OUT;
               endcase
            end
         end
         S_RD: begin
            unique case (rgg_pkg::op_type'(req_ff.operation))
               rgg_pkg::OP_LOAD: begin
                  start_in = rd_data.end_off;
                  st_in = S_PREV;
               end
               rgg_pkg::OP_INDEX: begin
                  if ({1'b0, req_ff.flat_index} >= rd_data.end_off) begin
                     rsp_in.status = 1'b1;
                     st_in = S_OUT;
                  end else begin
                     rd_addr = mid;
                     st_in = S_SRCH;
                  end
               end
               default: begin
                  // column/row: previous row end, then the row itself
                  start_in = (req_ff.row == '0) ? '0 : rd_data.end_off;
                  rd_addr = req_ff.row;
                  st_in = S_FIN2;
               end
            endcase
         end
         S_PREV: begin
            wr_en = 1'b1;
            st_in = S_OUT;
         end
         S_SRCH: begin
            // lo < hi here; rd_data is end offset of mid
            if (lo_ff == hi_ff) begin
               req_in.row = lo_ff;
               rd_addr = lo_ff - 1'b1;
               st_in = S_FIN;
            end else begin
               if (rd_data.end_off > {1'b0, req_ff.flat_index}) hi_in = mid;
               else lo_in = mid + 1'b1;
               rd_addr = RB'(({1'b0, lo_in} + {1'b0, hi_in}) >> 1);
               if (lo_in == hi_in) begin
                  req_in.row = lo_in;
                  rd_addr = lo_in - 1'b1;
                  st_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            // finish as a column/row lookup: previous row's end offset first
            rd_addr = req_ff.row - 1'b1;
            st_in = S_RD;
            req_in.operation = rgg_pkg::OP_COLROW;
            req_in.column = '0;
            phase_in = 2'd1;
         end
         S_FIN2: begin
            ent_in = rd_data;
            rsp_in.row_found = req_ff.row;
            rsp_in.latitude_out = rd_data.lat;
            if (phase_ff == 2'd1) begin
               rsp_in.column_found = rgg_pkg::ColBits'(
                  {1'b0, req_ff.flat_index} - start_ff);
               rsp_in.index_found = req_ff.flat_index;
               st_in = S_DIV;
            end else if (req_ff.column >= rd_data.points) begin
               rsp_in = '0;
               rsp_in.status = 1'b1;
               st_in = S_OUT;
            end else begin
               rsp_in.column_found = req_ff.column;
               rsp_in.index_found = rgg_pkg::IdxBits'(start_ff
                  + rgg_pkg::EndBits'(req_ff.column));
               st_in = S_DIV;
            end
            phase_in = 2'd2;
         end
         S_DIV: begin
            if (phase_ff == 2'd2) begin
               if (ent_ff.points == '0) begin
                  st_in = S_OUT;
               end else begin
                  div_start = 1'b1;
               end
               phase_in = 2'd3;
            end else if (div_done) begin
               rsp_in.longitude = quo;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            rspv_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         rspv_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rspv_ff <= rspv_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      phase_ff <= phase_in;
      start_ff <= start_in;
      ent_ff   <= ent_in;
   end

   assign req_ready = (st_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for reduced_gaussian_grid_indexer_top
// depends on rgg_pkg and the indexer rtl; the row table is mirrored here to predict each answer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   rgg_pkg::req_type req_data;
   rgg_pkg::rsp_type rsp_data;
   logic [rgg_pkg::RowBits-1:0] csr_data;

   reduced_gaussian_grid_indexer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // mirror of the row table and the half_rows register
   bit [rgg_pkg::RowBits-1:0] half_rows;
   bit [rgg_pkg::ColBits-1:0] row_pts [rgg_pkg::MaxRows];
   bit [rgg_pkg::EndBits-1:0] row_end [rgg_pkg::MaxRows];
   bit [rgg_pkg::LatBits-1:0] row_lat [rgg_pkg::MaxRows];
   int rows_loaded;
   rgg_pkg::rsp_type pending_answers[$];
   int errors;
   bit idle_on;
   bit hold_long;

   typedef struct {
      rgg_pkg::req_type w;
      bit typed;
      rgg_pkg::rsp_type want;
   } probe_type;
   probe_type probes[$];

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int grid_rows();
      int n;
      n = 2 * int'(half_rows);
      return (n > rgg_pkg::MaxRows) ? rgg_pkg::MaxRows : n;
   endfunction

   function automatic bit [rgg_pkg::LonBits-1:0] lon_of(longint unsigned col,
                                                         longint unsigned pts);
      if (pts == 0) return '0;
      return rgg_pkg::LonBits'(((col * 360) << 20) / pts);
   endfunction

   function automatic rgg_pkg::rsp_type grid_answer(rgg_pkg::req_type w);
      rgg_pkg::rsp_type a;
      int nrows, lo, hi, mid;
      longint unsigned start, c, pts;
      a = '0;
      nrows = grid_rows();
      case (rgg_pkg::op_type'(w.operation))
         rgg_pkg::OP_LOAD: begin
            if (w.row >= nrows) begin
               a.status = 1'b1;
            end else begin
               pts = (w.points > rgg_pkg::MaxRowPoints) ? rgg_pkg::MaxRowPoints : w.points;
               start = (w.row == 0) ? 0 : row_end[w.row - 1];
               row_pts[w.row] = rgg_pkg::ColBits'(pts);
               row_lat[w.row] = w.latitude;
               row_end[w.row] = rgg_pkg::EndBits'(start + pts);
               if (w.row == rows_loaded) rows_loaded++;
            end
         end
         rgg_pkg::OP_INDEX: begin
            if (nrows == 0 || w.flat_index >= row_end[nrows-1]) begin
               a.status = 1'b1;
            end else begin
               lo = 0;
               hi = nrows - 1;
               // first row whose end offset is past the index
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (row_end[mid] > w.flat_index) hi = mid;
                  else lo = mid + 1;
               end
               start = (lo == 0) ? 0 : row_end[lo-1];
               c = (longint'(w.flat_index) - start) & 64'h1FFF;
               a.row_found = rgg_pkg::RowBits'(lo);
               a.column_found = rgg_pkg::ColBits'(c);
               a.index_found = w.flat_index;
               a.longitude = lon_of(c, row_pts[lo]);
               a.latitude_out = row_lat[lo];
            end
         end
         rgg_pkg::OP_COLROW: begin
            if (w.row >= nrows || w.column >= row_pts[w.row]) begin
               a.status = 1'b1;
            end else begin
               start = (w.row == 0) ? 0 : row_end[w.row - 1];
               a.row_found = w.row;
               a.column_found = w.column;
               a.index_found = rgg_pkg::IdxBits'(start + w.column);
               a.longitude = lon_of(w.column, row_pts[w.row]);
               a.latitude_out = row_lat[w.row];
            end
         end
         default: a.status = 1'b1;
      endcase
      return a;
   endfunction

   function automatic rgg_pkg::req_type mk_req(rgg_pkg::op_type op, int row, int col,
                                                int pts, int lat, int idx);
      rgg_pkg::req_type w;
      w.operation = op;
      w.row = rgg_pkg::RowBits'(row);
      w.column = rgg_pkg::ColBits'(col);
      w.points = rgg_pkg::ColBits'(pts);
      w.latitude = rgg_pkg::LatBits'(lat);
      w.flat_index = rgg_pkg::IdxBits'(idx);
      return w;
   endfunction

   function automatic rgg_pkg::req_type next_word();
      rgg_pkg::req_type w;
      int nrows, avail, k, load_pct, r, total;
      w.operation = 2'($urandom);
      w.row = rgg_pkg::RowBits'($urandom);
      w.column = rgg_pkg::ColBits'($urandom);
      w.points = rgg_pkg::ColBits'($urandom);
      w.latitude = rgg_pkg::LatBits'($urandom);
      w.flat_index = rgg_pkg::IdxBits'($urandom);
      nrows = grid_rows();
      avail = (rows_loaded < nrows) ? rows_loaded : nrows;
      load_pct = (nrows >= 512) ? 95 : 30;
      k = $urandom_range(0, 99);
      if (rows_loaded < nrows && k < load_pct || (k >= 8 && k < 12 && avail > 0)) begin
         w.operation = rgg_pkg::OP_LOAD;
         w.row = rgg_pkg::RowBits'((rows_loaded < nrows && k < load_pct)
                                   ? rows_loaded : $urandom_range(0, avail-1));
         case ($urandom_range(0, 9))
            0: w.points = '0;
            1: w.points = rgg_pkg::ColBits'(rgg_pkg::MaxRowPoints);
            2: w.points = rgg_pkg::ColBits'($urandom_range(0, rgg_pkg::MaxRowPoints));
            default: w.points = rgg_pkg::ColBits'($urandom_range(1, 40));
         endcase
         w.latitude = rgg_pkg::LatBits'(int'($urandom_range(0, 2*94371840)) - 94371840);
      end else if (k < 8 || avail == 0) begin
         // words the block rejects: bad op, a row outside the grid, or an index on an empty grid
         if (nrows < rgg_pkg::MaxRows && $urandom_range(0, 1)) begin
            w.operation = $urandom_range(0, 1) ? rgg_pkg::OP_LOAD : rgg_pkg::OP_COLROW;
            w.row = rgg_pkg::RowBits'($urandom_range(nrows, rgg_pkg::MaxRows-1));
         end else if (nrows == 0 && $urandom_range(0, 1)) begin
            w.operation = rgg_pkg::OP_INDEX;
         end else begin
            w.operation = rgg_pkg::OP_BAD;
         end
      end else if (k < 55 || rows_loaded < nrows) begin
         w.operation = rgg_pkg::OP_COLROW;
         r = $urandom_range(0, avail-1);
         w.row = rgg_pkg::RowBits'(r);
         if (row_pts[r] > 0 && $urandom_range(0, 4) != 0)
            w.column = rgg_pkg::ColBits'($urandom_range(0, row_pts[r]-1));
         else if ($urandom_range(0, 1))
            w.column = row_pts[r];
      end else begin
         w.operation = rgg_pkg::OP_INDEX;
         total = int'(row_end[nrows-1]);
         if (total > 0 && $urandom_range(0, 4) != 0)
            w.flat_index = rgg_pkg::IdxBits'($urandom_range(0, total-1));
         else
            w.flat_index = rgg_pkg::IdxBits'($urandom_range(total, 16775168));
      end
      return w;
   endfunction

   // called at a rising edge; returns at the edge where the word is taken
   task automatic put_word(rgg_pkg::req_type w, bit typed, rgg_pkg::rsp_type want);
      rgg_pkg::rsp_type predicted;
      bit fire;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      predicted = grid_answer(w);
      pending_answers.insert(pending_answers.size(), typed ? want : predicted);
      do begin
         @(negedge clock);
         fire = req_ready;
         @(posedge clock);
      end while (!fire);
   endtask

   task automatic write_half_rows(int value);
      bit fire;
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= rgg_pkg::RowBits'(value);
      do begin
         @(negedge clock);
         fire = csr_ready;
         @(posedge clock);
      end while (!fire);
      csr_valid <= 1'b0;
      half_rows = rgg_pkg::RowBits'(value);
   endtask

   task automatic run_phase(int hr, int count, bit fill, bit press);
      int i;
      write_half_rows(hr);
      idle_on = ($urandom_range(0, 3) != 0);
      i = 0;
      while (i < count || (fill && rows_loaded < grid_rows())) begin
         if (press && i == count/3) hold_long = 1'b1;
         // quiet tail of the run
         if (fill && i >= count - 200) idle_on = 1'b0;
         put_word(next_word(), 1'b0, '0);
         i++;
      end
   endtask

   // result side: random stall bursts, one long hold on request
   initial begin
      int rx_hold;
      rx_hold = 0;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long) begin
            hold_long = 1'b0;
            rx_hold = 300;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each taken word with the oldest prediction
   always @(negedge clock) begin
      rgg_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.row_found !== want.row_found) begin
               $error("row_found expected %0d actual %0d", want.row_found, rsp_data.row_found);
               errors++;
            end
            if (rsp_data.column_found !== want.column_found) begin
               $error("column_found expected %0d actual %0d",
                      want.column_found, rsp_data.column_found);
               errors++;
            end
            if (rsp_data.index_found !== want.index_found) begin
               $error("index_found expected %0d actual %0d",
                      want.index_found, rsp_data.index_found);
               errors++;
            end
            if (rsp_data.longitude !== want.longitude) begin
               $error("longitude expected %0d actual %0d", want.longitude, rsp_data.longitude);
               errors++;
            end
            if (rsp_data.latitude_out !== want.latitude_out) begin
               $error("latitude_out expected %0d actual %0d",
                      want.latitude_out, rsp_data.latitude_out);
               errors++;
            end
         end
      end
   end

   task automatic add_probe(rgg_pkg::req_type w, bit typed, rgg_pkg::rsp_type want);
      probe_type p;
      p.w = w;
      p.typed = typed;
      p.want = want;
      probes.insert(probes.size(), p);
   endtask

   initial begin
      rgg_pkg::rsp_type ok_word, reject_word;
      int k;
      errors = 0;
      half_rows = 1;
      rows_loaded = 0;
      idle_on = 1'b1;
      hold_long = 1'b0;
      ok_word = '0;
      reject_word = '0;
      reject_word.status = 1'b1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, two rows after reset
      add_probe(mk_req(rgg_pkg::OP_LOAD, 0, 0, rgg_pkg::MaxRowPoints, 94371840, 0),
                1, ok_word);
      add_probe(mk_req(rgg_pkg::OP_LOAD, 1, 8191, 0, -94371840, 16775168), 1, ok_word);
      add_probe(mk_req(rgg_pkg::OP_LOAD, 2, 0, 7, 0, 0), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 2047, 8191, 8191, -1, 0), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 8190), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 8191), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 16775168), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 0, 0, 0, 0, 0), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 0, 8190, 0, 0, 0), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 1, 0, 0, 0, 0), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 2047, 0, 0, 0, 0), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_BAD, 2047, 8191, 8191, -1, 16777215), 1, reject_word);
      add_probe(mk_req(rgg_pkg::OP_LOAD, 1, 0, 5, 0, 0), 1, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 8191), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 8195), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 1, 4, 0, 0, 0), 0, ok_word);
      // empty first row: index search skips it
      add_probe(mk_req(rgg_pkg::OP_LOAD, 0, 0, 0, 1048576, 0), 1, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 0), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_INDEX, 0, 0, 0, 0, 7), 0, ok_word);
      add_probe(mk_req(rgg_pkg::OP_COLROW, 0, 0, 0, 0, 0), 1, reject_word);
      for (k = 0; k < probes.size(); k++)
         put_word(probes[k].w, probes[k].typed, probes[k].want);

      run_phase(5, 200, 0, 1);
      run_phase(0, 40, 0, 0);
      run_phase(1, 60, 0, 0);
      run_phase($urandom_range(10, 40), 250, 0, 0);
      run_phase(2047, 150, 0, 0);
      run_phase(512, 900, 1, 0);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/rgg_pkg.sv
sv/rgg_row_mem.sv
sv/rgg_divider.sv
sv/reduced_gaussian_grid_indexer_top.sv
bench/testbench.sv
